### rtl/micp_pkg.sv
// Shared constants and control/status types for the interval coverage block.
`default_nettype none
package micp_pkg;

  localparam int unsigned MICP_VALUE_RANGE   = 1024;
  localparam int unsigned MICP_MAX_INTERVALS = 65535;
  localparam int unsigned MICP_TALLY_CAP     = 65535;

  localparam int unsigned MICP_COORD_W = 10;
  localparam int unsigned MICP_COUNT_W = 16;
  localparam int unsigned MICP_DIFF_W  = 17;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // request taken this cycle
    logic inc;       // +1 at start, fetch end+1
    logic dec;       // -1 at end+1
    logic clr;       // post-reset clearing pass
    logic scan;      // prefix-sum walk, zeroing as it goes
    logic out_load;  // move best into the output register
  } micp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;
    logic item_last;
    logic out_free;
  } micp_sts_t;

endpackage
`default_nettype wire

### rtl/micp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module micp_ram
  import micp_pkg::*;
#(
  parameter int unsigned WIDTH = MICP_DIFF_W,
  parameter int unsigned DEPTH = MICP_VALUE_RANGE,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/micp_ctrl.sv
// Sequencer for request updates, the coverage scan and the clearing pass.
`default_nettype none
module micp_ctrl
  import micp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire micp_sts_t sts,
  output micp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_DEC,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (sts.idx_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state <= ST_INC;
        end
        ST_INC: begin
          state <= ST_DEC;
        end
        ST_DEC: begin
          state <= sts.item_last ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          if (sts.idx_last) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == ST_IDLE) && in_valid;
    cmd.inc      = (state == ST_INC);
    cmd.dec      = (state == ST_DEC);
    cmd.clr      = (state == ST_CLEAR);
    cmd.scan     = (state == ST_SCAN);
    cmd.out_load = (state == ST_DONE) && sts.out_free;
  end

endmodule
`default_nettype wire

### rtl/micp_dp.sv
// Difference memory, interval tally, prefix-sum scan and result register.
`default_nettype none
module micp_dp
  import micp_pkg::*;
#(
  parameter int unsigned VALUE_RANGE   = MICP_VALUE_RANGE,
  parameter int unsigned MAX_INTERVALS = MICP_MAX_INTERVALS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire micp_cmd_t               cmd,
  output micp_sts_t                    sts,
  input  wire logic [MICP_COORD_W-1:0] start_req,
  input  wire logic [MICP_COORD_W-1:0] finish,
  input  wire logic                    last,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [MICP_COORD_W-1:0] best_value,
  output logic      [MICP_COUNT_W-1:0] best_count
);

  localparam int unsigned AW    = $clog2(VALUE_RANGE);
  localparam int unsigned CMP_W = (AW + 1 > MICP_COORD_W + 1) ? AW + 1 : MICP_COORD_W + 1;
  localparam logic [MICP_COUNT_W-1:0] TALLY_LIMIT =
    (MAX_INTERVALS > MICP_TALLY_CAP) ? MICP_COUNT_W'(MICP_TALLY_CAP)
                                     : MICP_COUNT_W'(MAX_INTERVALS);
  localparam logic [CMP_W-1:0] RANGE_CMP = CMP_W'(VALUE_RANGE);
  localparam logic [AW-1:0]    IDX_LAST  = AW'(VALUE_RANGE - 1);

  // request latched at accept
  logic [MICP_COORD_W-1:0] lo;
  logic [AW-1:0]           hi1_addr;
  logic                    take;
  logic                    dec_ok;
  logic                    item_last;

  logic [MICP_COUNT_W-1:0] tally;
  logic [AW-1:0]           idx;
  logic [AW-1:0]           idx_d;
  logic                    scan_v;

  logic signed [MICP_DIFF_W-1:0] running_sum;
  logic signed [MICP_DIFF_W-1:0] running_sum_next;
  logic        [MICP_COUNT_W-1:0] top_count;
  logic        [AW-1:0]           top_idx;

  logic [MICP_COORD_W:0]   hi1;
  logic                    take_next;
  logic                    dec_next;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [MICP_DIFF_W-1:0]  wdata;
  logic [AW-1:0]           raddr;
  logic [MICP_DIFF_W-1:0]  rdata;

  assign hi1       = (MICP_COORD_W + 1)'(finish) + 1'b1;
  assign take_next = (start_req <= finish) && (CMP_W'(start_req) < RANGE_CMP)
                     && (tally < TALLY_LIMIT);
  assign dec_next  = (CMP_W'(hi1) < RANGE_CMP);

  assign sts.idx_last  = (idx == IDX_LAST);
  assign sts.item_last = item_last;
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lo        <= start_req;
      hi1_addr  <= AW'(hi1);
      take      <= take_next;
      dec_ok    <= dec_next;
      item_last <= last;
    end
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    raddr = AW'(start_req);
    if (cmd.clr || cmd.scan) begin
      we    = 1'b1;
      raddr = idx;
    end else if (cmd.inc) begin
      we    = take;
      waddr = AW'(lo);
      wdata = rdata + MICP_DIFF_W'(1);
      raddr = hi1_addr;
    end else if (cmd.dec) begin
      we    = take && dec_ok;
      waddr = hi1_addr;
      wdata = rdata - MICP_DIFF_W'(1);
    end
  end

  micp_ram #(
    .WIDTH (MICP_DIFF_W),
    .DEPTH (VALUE_RANGE)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clr || cmd.scan) begin
      idx <= sts.idx_last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (cmd.out_load) begin
      tally <= '0;
    end else if (cmd.inc && take) begin
      tally <= tally + 1'b1;
    end
  end

  assign running_sum_next = running_sum + $signed(rdata);

  // read data arrives the cycle after the scan address, as the RAM read is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_v      <= 1'b0;
      running_sum <= '0;
      top_count   <= '0;
      top_idx     <= '0;
    end else begin
      scan_v <= cmd.scan;
      if (cmd.out_load) begin
        running_sum <= '0;
        top_count   <= '0;
        top_idx     <= '0;
      end else if (scan_v) begin
        running_sum <= running_sum_next;
        // strict compare keeps the lowest value on a tie
        if (running_sum_next > $signed({1'b0, top_count})) begin
          top_count <= MICP_COUNT_W'(running_sum_next);
          top_idx   <= idx_d;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      idx_d <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      best_value <= MICP_COORD_W'(top_idx);
      best_count <= top_count;
    end
  end

`ifndef SYNTHESIS
  a_tally_cap: assert property (@(posedge clk) disable iff (rst)
    tally <= TALLY_LIMIT)
    else $error("interval tally above its limit");

  a_sum_nonneg: assert property (@(posedge clk) disable iff (rst)
    !running_sum[MICP_DIFF_W-1])
    else $error("prefix sum went negative");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  a_cleared_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (tally == '0) && (running_sum == '0) && out_valid)
    else $error("state not cleared after result load");

  a_best_bounded: assert property (@(posedge clk) disable iff (rst)
    top_count <= TALLY_LIMIT)
    else $error("best count above tally limit");
`endif

endmodule
`default_nettype wire

### rtl/max_interval_coverage_point.sv
// Top level: most-covered point of a set of closed intervals.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid / in_stall | start_req, finish, last
//  out     | output    | out_valid/out_stall | best_value, best_count
//
// An interval request passes through the INC and DEC states: two read-modify-writes
// on the one write port of the difference memory, with the registered read overlapped.
// A request marked last then runs the SCAN, DRAIN and DONE states: the scan walks one
// memory entry per cycle and zeroes it behind the read.
// After reset the memory is cleared entry by entry with in_stall high.
// A finished result waits in the output register; new requests are taken
// meanwhile, and only the next result load waits for out_stall to drop.
`default_nettype none
module max_interval_coverage_point
  import micp_pkg::*;
#(
  parameter int unsigned VALUE_RANGE   = MICP_VALUE_RANGE,
  parameter int unsigned MAX_INTERVALS = MICP_MAX_INTERVALS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [MICP_COORD_W-1:0] start_req,
  input  wire logic [MICP_COORD_W-1:0] finish,
  input  wire logic                    last,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [MICP_COORD_W-1:0] best_value,
  output logic      [MICP_COUNT_W-1:0] best_count
);

  micp_cmd_t cmd;
  micp_sts_t sts;

  micp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  micp_dp #(
    .VALUE_RANGE   (VALUE_RANGE),
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .start_req  (start_req),
    .finish     (finish),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_value (best_value),
    .best_count (best_count)
  );

endmodule
`default_nettype wire
